// ----- design/hbm_pkg.sv -----
// Shared types and codes for the heartbeat membership table.
// Used by hbm_ctrl, hbm_datapath and heartbeat_membership_table; no dependencies.
`default_nettype none

package hbm_pkg;

	// Request codes carried in the input tuser.
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_MSG   = 2'd2;

	// Message kinds, both received and sent.
	localparam logic [1:0] MSG_JOIN_REQ = 2'd0;
	localparam logic [1:0] MSG_JOIN_REP = 2'd1;
	localparam logic [1:0] MSG_BEAT     = 2'd2;

	// Result event codes.
	localparam logic [1:0] EV_SEND   = 2'd0;
	localparam logic [1:0] EV_ADDED  = 2'd1;
	localparam logic [1:0] EV_REMOVE = 2'd2;
	localparam logic [1:0] EV_DROP   = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SELF_ID    = 3'd0;
	localparam logic [2:0] CFG_SELF_PORT  = 3'd1;
	localparam logic [2:0] CFG_INTRO_ID   = 3'd2;
	localparam logic [2:0] CFG_INTRO_PORT = 3'd3;
	localparam logic [2:0] CFG_PERIOD     = 3'd4;
	localparam logic [2:0] CFG_TIMEOUT    = 3'd5;

	// Results per input item are capped at this count.
	localparam logic [4:0] MAX_RESULTS = 5'd30;

	// One table entry.
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] port;
		logic [31:0] beat;
		logic [31:0] heard;
	} entry_t;

	// One result word, without the last marker.
	typedef struct packed {
		logic [1:0]  event_kind;
		logic [1:0]  send_kind;
		logic [31:0] dest_id;
		logic [15:0] dest_port;
		logic [31:0] about_id;
		logic [15:0] about_port;
		logic [31:0] beat_value;
	} res_t;

	// Which result the datapath builds.
	typedef enum logic [2:0] {
		ES_ADD_SELF = 3'd0,
		ES_JOIN_REQ = 3'd1,
		ES_JOIN_REP = 3'd2,
		ES_FORWARD  = 3'd3,
		ES_ADD_SRC  = 3'd4,
		ES_DROP     = 3'd5,
		ES_PING     = 3'd6,
		ES_REMOVE   = 3'd7
	} emit_sel_t;

	// Which data the datapath writes into the table.
	typedef enum logic [1:0] {
		WS_SELF = 2'd0,
		WS_SRC  = 2'd1,
		WS_COPY = 2'd2,
		WS_BEAT = 2'd3
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      rd_en;
		logic      wr_en;
		wr_sel_t   wr_sel;
		logic      emit;
		emit_sel_t emit_sel;
		logic      flush;
		logic      start_init;
		logic      set_group;
		logic      ping_fire;
		logic      ping_dec;
		logic      count_inc;
		logic      count_ld;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] msg_kind;
		logic       in_group;
		logic       ping_zero;
		logic       self_is_intro;
		logic       rd_is_src;
		logic       rd_is_self;
		logic       rd_newer;
		logic       rd_stale;
		logic       cap_ok;
		logic       can_push;
		logic       pend_v;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/hbm_datapath.sv -----
// Datapath of the heartbeat membership table: peer table memory, configuration,
// node state and the result buffering. Depends on hbm_pkg.
`default_nettype none

module hbm_datapath #(
	parameter int TABLE_DEPTH = 16,
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_wdata,
	input  wire logic [3:0]         s_tuser,
	input  wire logic [111:0]       s_tdata,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [127:0]            m_tdata,
	output logic [3:0]              m_tuser,
	output logic                    m_tlast,
	input  wire hbm_pkg::cmd_t      cmd,
	input  wire logic [IW-1:0]      rd_addr,
	input  wire logic [IW-1:0]      wr_addr,
	input  wire logic [CW-1:0]      keep_count,
	output hbm_pkg::sts_t           sts,
	output logic [CW-1:0]           count
);

	// Configuration registers.
	logic [31:0] self_id_q, intro_id_q;
	logic [15:0] self_port_q, intro_port_q, timeout_q;
	logic [7:0]  period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q    <= '0;
			self_port_q  <= '0;
			intro_id_q   <= 32'd1;
			intro_port_q <= '0;
			period_q     <= 8'd5;
			timeout_q    <= 16'd20;
		end else if (cfg_we) begin
			case (cfg_index)
				hbm_pkg::CFG_SELF_ID:    self_id_q    <= cfg_wdata;
				hbm_pkg::CFG_SELF_PORT:  self_port_q  <= cfg_wdata[15:0];
				hbm_pkg::CFG_INTRO_ID:   intro_id_q   <= cfg_wdata;
				hbm_pkg::CFG_INTRO_PORT: intro_port_q <= cfg_wdata[15:0];
				hbm_pkg::CFG_PERIOD:     period_q     <= cfg_wdata[7:0];
				hbm_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Input word of the item in work.
	logic [1:0]  req_q, kind_q;
	logic [31:0] now_q, src_id_q, beat_in_q;
	logic [15:0] src_port_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= s_tuser[1:0];
			kind_q     <= s_tuser[3:2];
			now_q      <= s_tdata[31:0];
			src_id_q   <= s_tdata[63:32];
			src_port_q <= s_tdata[79:64];
			beat_in_q  <= s_tdata[111:80];
		end
	end

	// Node state.
	logic [CW-1:0] count_q;
	logic [31:0]   own_beat_q;
	logic [7:0]    ping_q;
	logic          group_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			own_beat_q <= '0;
			ping_q     <= '0;
			group_q    <= 1'b0;
		end else begin
			if (cmd.start_init) begin
				count_q    <= CW'(1);
				own_beat_q <= '0;
				ping_q     <= period_q;
				group_q    <= 1'b0;
			end
			if (cmd.set_group)
				group_q <= 1'b1;
			if (cmd.count_inc)
				count_q <= count_q + CW'(1);
			if (cmd.count_ld)
				count_q <= keep_count;
			if (cmd.ping_fire) begin
				own_beat_q <= own_beat_q + 32'd1;
				ping_q     <= period_q;
			end
			if (cmd.ping_dec)
				ping_q <= ping_q - 8'd1;
		end
	end

	assign count = count_q;

	// Peer table: one write and one registered read per cycle.
	hbm_pkg::entry_t mem [TABLE_DEPTH];
	hbm_pkg::entry_t rd_q;
	hbm_pkg::entry_t wr_data;

	always_comb begin
		case (cmd.wr_sel)
			hbm_pkg::WS_SELF: wr_data = {self_id_q, self_port_q, 32'd0, now_q};
			hbm_pkg::WS_SRC:  wr_data = {src_id_q, src_port_q, beat_in_q, now_q};
			hbm_pkg::WS_COPY: wr_data = rd_q;
			hbm_pkg::WS_BEAT: wr_data = {rd_q.id, rd_q.port, own_beat_q, rd_q.heard};
			default:          wr_data = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	// Result built for the current emit command.
	hbm_pkg::res_t res;

	always_comb begin
		res = '0;
		case (cmd.emit_sel)
			hbm_pkg::ES_ADD_SELF: begin
				res.event_kind = hbm_pkg::EV_ADDED;
				res.about_id   = self_id_q;
				res.about_port = self_port_q;
			end
			hbm_pkg::ES_JOIN_REQ: begin
				res.event_kind = hbm_pkg::EV_SEND;
				res.send_kind  = hbm_pkg::MSG_JOIN_REQ;
				res.dest_id    = intro_id_q;
				res.dest_port  = intro_port_q;
				res.about_id   = self_id_q;
				res.about_port = self_port_q;
				res.beat_value = own_beat_q;
			end
			hbm_pkg::ES_JOIN_REP: begin
				res.event_kind = hbm_pkg::EV_SEND;
				res.send_kind  = hbm_pkg::MSG_JOIN_REP;
				res.dest_id    = src_id_q;
				res.dest_port  = src_port_q;
				res.about_id   = self_id_q;
				res.about_port = self_port_q;
				res.beat_value = own_beat_q;
			end
			hbm_pkg::ES_FORWARD: begin
				res.event_kind = hbm_pkg::EV_SEND;
				res.send_kind  = hbm_pkg::MSG_BEAT;
				res.dest_id    = rd_q.id;
				res.dest_port  = rd_q.port;
				res.about_id   = src_id_q;
				res.about_port = src_port_q;
				res.beat_value = beat_in_q;
			end
			hbm_pkg::ES_ADD_SRC: begin
				res.event_kind = hbm_pkg::EV_ADDED;
				res.about_id   = src_id_q;
				res.about_port = src_port_q;
			end
			hbm_pkg::ES_DROP: begin
				res.event_kind = hbm_pkg::EV_DROP;
				res.about_id   = src_id_q;
				res.about_port = src_port_q;
			end
			hbm_pkg::ES_PING: begin
				res.event_kind = hbm_pkg::EV_SEND;
				res.send_kind  = hbm_pkg::MSG_BEAT;
				res.dest_id    = rd_q.id;
				res.dest_port  = rd_q.port;
				res.about_id   = self_id_q;
				res.about_port = self_port_q;
				res.beat_value = own_beat_q;
			end
			hbm_pkg::ES_REMOVE: begin
				res.event_kind = hbm_pkg::EV_REMOVE;
				res.about_id   = rd_q.id;
				res.about_port = rd_q.port;
			end
			default: res = '0;
		endcase
	end

	// A result is held back one step so that the final word can carry last.
	hbm_pkg::res_t pend_q, out_q;
	logic          pend_v_q, out_v_q, out_last_q;
	logic [4:0]    res_cnt_q;
	logic          cap_ok, can_push, take;

	assign cap_ok   = res_cnt_q < hbm_pkg::MAX_RESULTS;
	assign can_push = !out_v_q || m_tready;
	assign take     = cmd.emit && cap_ok && can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			res_cnt_q <= '0;
		end else begin
			if (m_tready)
				out_v_q <= 1'b0;
			if (cmd.load)
				res_cnt_q <= '0;
			if (take) begin
				res_cnt_q <= res_cnt_q + 5'd1;
				pend_v_q  <= 1'b1;
				if (pend_v_q)
					out_v_q <= 1'b1;
			end
			if (cmd.flush && can_push) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= res;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.flush && can_push) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_q.send_kind, out_q.event_kind};
	assign m_tdata  = {out_q.beat_value, out_q.about_port, out_q.about_id,
		out_q.dest_port, out_q.dest_id};

	// Status back to the controller.
	always_comb begin
		sts.req_type      = req_q;
		sts.msg_kind      = kind_q;
		sts.in_group      = group_q;
		sts.ping_zero     = ping_q == 8'd0;
		sts.self_is_intro = (self_id_q == intro_id_q) && (self_port_q == intro_port_q);
		sts.rd_is_src     = (rd_q.id == src_id_q) && (rd_q.port == src_port_q);
		sts.rd_is_self    = (rd_q.id == self_id_q) && (rd_q.port == self_port_q);
		sts.rd_newer      = beat_in_q > rd_q.beat;
		sts.rd_stale      = (now_q - rd_q.heard) > {16'd0, timeout_q};
		sts.cap_ok        = cap_ok;
		sts.can_push      = can_push;
		sts.pend_v        = pend_v_q;
	end

endmodule

`default_nettype wire

// ----- design/hbm_ctrl.sv -----
// Controller of the heartbeat membership table: sequences the table walks.
// Depends on hbm_pkg.
`default_nettype none

module hbm_ctrl #(
	parameter int TABLE_DEPTH = 16,
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire hbm_pkg::sts_t sts,
	input  wire logic [CW-1:0] count,
	output hbm_pkg::cmd_t      cmd,
	output logic [IW-1:0]      rd_addr,
	output logic [IW-1:0]      wr_addr,
	output logic [CW-1:0]      keep_count
);

	typedef enum logic [15:0] {
		ST_IDLE   = 16'h0001,
		ST_DISP   = 16'h0002,
		ST_START  = 16'h0004,
		ST_JOIN   = 16'h0008,
		ST_MSG    = 16'h0010,
		ST_LK_RD  = 16'h0020,
		ST_LK_EV  = 16'h0040,
		ST_BC_RD  = 16'h0080,
		ST_BC_EV  = 16'h0100,
		ST_APPEND = 16'h0200,
		ST_TICK   = 16'h0400,
		ST_PB_RD  = 16'h0800,
		ST_PB_EV  = 16'h1000,
		ST_RM_RD  = 16'h2000,
		ST_RM_EV  = 16'h4000,
		ST_FIN    = 16'h8000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] i_q, i_d, w_q, w_d;
	hbm_pkg::cmd_t c;
	logic          blocked;

	// Next state, counters and commands.
	always_comb begin
		c       = '0;
		state_d = state_q;
		i_d     = i_q;
		w_d     = w_q;
		wr_addr = i_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					c.load  = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.req_type)
					hbm_pkg::REQ_START: state_d = ST_START;
					hbm_pkg::REQ_TICK:
						state_d = (count != '0 && sts.in_group) ? ST_TICK : ST_FIN;
					hbm_pkg::REQ_MSG:
						state_d = (count != '0) ? ST_MSG : ST_FIN;
					default: state_d = ST_FIN;
				endcase
			end
			ST_START: begin
				c.start_init = 1'b1;
				c.wr_en      = 1'b1;
				c.wr_sel     = hbm_pkg::WS_SELF;
				wr_addr      = '0;
				c.emit       = 1'b1;
				c.emit_sel   = hbm_pkg::ES_ADD_SELF;
				state_d      = ST_JOIN;
			end
			ST_JOIN: begin
				if (sts.self_is_intro)
					c.set_group = 1'b1;
				else begin
					c.emit     = 1'b1;
					c.emit_sel = hbm_pkg::ES_JOIN_REQ;
				end
				state_d = ST_FIN;
			end
			ST_MSG: begin
				if (sts.msg_kind == hbm_pkg::MSG_JOIN_REQ) begin
					c.emit     = 1'b1;
					c.emit_sel = hbm_pkg::ES_JOIN_REP;
				end else if (sts.msg_kind == hbm_pkg::MSG_JOIN_REP)
					c.set_group = 1'b1;
				i_d     = '0;
				state_d = ST_LK_RD;
			end
			// Lookup of the sender, first match wins.
			ST_LK_RD: begin
				if (i_q < count) begin
					c.rd_en = 1'b1;
					state_d = ST_LK_EV;
				end else
					state_d = ST_APPEND;
			end
			ST_LK_EV: begin
				if (sts.rd_is_src) begin
					if (sts.rd_newer) begin
						c.wr_en  = 1'b1;
						c.wr_sel = hbm_pkg::WS_SRC;
						i_d      = CW'(1);
						state_d  = ST_BC_RD;
					end else
						state_d = ST_FIN;
				end else begin
					i_d     = i_q + CW'(1);
					state_d = ST_LK_RD;
				end
			end
			// Forward a newer heartbeat to every peer but self.
			ST_BC_RD: begin
				if (i_q < count) begin
					c.rd_en = 1'b1;
					state_d = ST_BC_EV;
				end else
					state_d = ST_FIN;
			end
			ST_BC_EV: begin
				if (!sts.rd_is_self) begin
					c.emit     = 1'b1;
					c.emit_sel = hbm_pkg::ES_FORWARD;
				end
				i_d     = i_q + CW'(1);
				state_d = ST_BC_RD;
			end
			ST_APPEND: begin
				c.emit = 1'b1;
				if (count < CW'(TABLE_DEPTH)) begin
					c.wr_en     = 1'b1;
					c.wr_sel    = hbm_pkg::WS_SRC;
					wr_addr     = count[IW-1:0];
					c.count_inc = 1'b1;
					c.emit_sel  = hbm_pkg::ES_ADD_SRC;
				end else
					c.emit_sel = hbm_pkg::ES_DROP;
				state_d = ST_FIN;
			end
			ST_TICK: begin
				if (sts.ping_zero) begin
					c.ping_fire = 1'b1;
					i_d         = '0;
					state_d     = ST_PB_RD;
				end else begin
					c.ping_dec = 1'b1;
					i_d        = CW'(1);
					w_d        = CW'(1);
					state_d    = ST_RM_RD;
				end
			end
			// Own heartbeat broadcast.
			ST_PB_RD: begin
				if (i_q < count) begin
					c.rd_en = 1'b1;
					state_d = ST_PB_EV;
				end else begin
					i_d     = CW'(1);
					w_d     = CW'(1);
					state_d = ST_RM_RD;
				end
			end
			ST_PB_EV: begin
				if (sts.rd_is_self) begin
					c.wr_en  = 1'b1;
					c.wr_sel = hbm_pkg::WS_BEAT;
				end else begin
					c.emit     = 1'b1;
					c.emit_sel = hbm_pkg::ES_PING;
				end
				i_d     = i_q + CW'(1);
				state_d = ST_PB_RD;
			end
			// Removal pass: read at i, compact survivors down to w.
			ST_RM_RD: begin
				if (i_q < count) begin
					c.rd_en = 1'b1;
					state_d = ST_RM_EV;
				end else begin
					c.count_ld = 1'b1;
					state_d    = ST_FIN;
				end
			end
			ST_RM_EV: begin
				if (sts.rd_stale) begin
					c.emit     = 1'b1;
					c.emit_sel = hbm_pkg::ES_REMOVE;
				end else begin
					c.wr_en  = 1'b1;
					c.wr_sel = hbm_pkg::WS_COPY;
					wr_addr  = w_q[IW-1:0];
					w_d      = w_q + CW'(1);
				end
				i_d     = i_q + CW'(1);
				state_d = ST_RM_RD;
			end
			ST_FIN: begin
				c.flush = sts.pend_v;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase

		// Hold everything while a result cannot be placed.
		blocked = ((c.emit && sts.cap_ok) || c.flush) && !sts.can_push;
		if (blocked) begin
			c       = '0;
			state_d = state_q;
			i_d     = i_q;
			w_d     = w_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			w_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			w_q     <= w_d;
		end
	end

	assign cmd        = c;
	assign rd_addr    = i_q[IW-1:0];
	assign keep_count = w_q;
	assign s_tready   = state_q == ST_IDLE;

endmodule

`default_nettype wire

// ----- design/heartbeat_membership_table.sv -----
// Top level of the heartbeat membership table.
// Depends on hbm_pkg, hbm_ctrl and hbm_datapath.
//
// The block keeps an ordered table of up to TABLE_DEPTH group members, entry 0 being
// this node, and handles one input word at a time: a start, a tick or a received
// message. Each word produces zero to thirty result words, the final one marked with
// tlast. A message or a tick walks the table entry by entry in each pass, through a
// memory with a separate write port and a registered read. A result output that is
// not taken stalls the walk. The table needs no clearing after reset.
`default_nettype none

module heartbeat_membership_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// now_time[31:0], src_id[63:32], src_port[79:64], msg_heartbeat[111:80]
	input  wire logic [111:0] s_tdata,
	// req_type[1:0], msg_kind[3:2]
	input  wire logic [3:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// dest_id[31:0], dest_port[47:32], about_id[79:48], about_port[95:80],
	// beat_value[127:96]
	output logic [127:0]      m_tdata,
	// event_kind[1:0], send_kind[3:2]
	output logic [3:0]        m_tuser,
	output logic              m_tlast
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	hbm_pkg::cmd_t cmd;
	hbm_pkg::sts_t sts;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [CW-1:0] keep_count, count;

	hbm_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IW(IW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.count(count),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.keep_count(keep_count)
	);

	hbm_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.IW(IW),
		.CW(CW)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.keep_count(keep_count),
		.sts(sts),
		.count(count)
	);

`ifndef SYNTHESIS
	// The table never holds more entries than it has room for.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// Only one word is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("word accepted while another is in work");

	// Reads stay inside the filled part of the table.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> CW'(rd_addr) < count)
		else $error("table read beyond entry count");

	// Writes land at most one past the filled part.
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && !cmd.start_init |-> CW'(wr_addr) <= count)
		else $error("table write beyond entry count");
`endif

endmodule

`default_nettype wire

// ----- tb/heartbeat_membership_table_tb.sv -----
// Self-checking testbench for heartbeat_membership_table: starts, ticks and messages
// are driven on the input stream and every result word is compared with a predictor.
// Depends on hbm_pkg and the design files only.
`timescale 1ns / 1ps

module heartbeat_membership_table_tb;

	localparam int DEPTH = 16;
	localparam int LIMIT = 2000000;
	// Codes that the block ignores or treats as a heartbeat.
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam logic [1:0] MSG_UNKNOWN = 2'd3;
	// Message kind sent along with words that are not messages.
	localparam logic [1:0] NO_KIND = 2'd0;

	typedef struct packed {
		logic [1:0]  ev;
		logic [1:0]  sk;
		logic [31:0] did;
		logic [15:0] dport;
		logic [31:0] aid;
		logic [15:0] aport;
		logic [31:0] beat;
		logic        lst;
	} word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_wdata = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [111:0] s_tdata = '0;
	logic [3:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [127:0] m_tdata;
	logic [3:0] m_tuser;
	logic m_tlast;

	heartbeat_membership_table #(.TABLE_DEPTH(DEPTH)) dut (.*);

	// Predictor state.
	logic [31:0] r_self_id, r_intro_id;
	logic [15:0] r_self_port, r_intro_port, r_timeout;
	logic [7:0]  r_period;
	int unsigned n_entries;
	logic [31:0] t_id [DEPTH];
	logic [15:0] t_port [DEPTH];
	logic [31:0] t_beat [DEPTH];
	logic [31:0] t_heard [DEPTH];
	logic [31:0] my_beat;
	logic [7:0]  countdown;
	logic        joined;

	word_t expected_words[$];
	word_t step_words[$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;
	int stall_req = 0;
	bit stall_taken = 0;
	logic [31:0] clock_now = 0;

	initial forever #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void add_word(logic [1:0] ev, logic [1:0] sk, logic [31:0] did,
			logic [15:0] dport, logic [31:0] aid, logic [15:0] aport, logic [31:0] beat);
		word_t w;
		if (step_words.size() >= int'(hbm_pkg::MAX_RESULTS))
			return;
		w = '{ev, sk, did, dport, aid, aport, beat, 1'b0};
		step_words = {step_words, w};
	endfunction

	function automatic logic entry_is_self(int i);
		return t_id[i] == r_self_id && t_port[i] == r_self_port;
	endfunction

	// Works out the result words of one input word and updates the table copy.
	function automatic void predict_membership(logic [1:0] req, logic [1:0] kind,
			logic [31:0] now, logic [31:0] sid, logic [15:0] sport, logic [31:0] mbeat);
		int i, k;
		bit found;
		step_words.delete();
		if (req == hbm_pkg::REQ_START) begin
			n_entries = 1;
			t_id[0] = r_self_id; t_port[0] = r_self_port; t_beat[0] = '0; t_heard[0] = now;
			my_beat = '0; joined = 1'b0; countdown = r_period;
			add_word(hbm_pkg::EV_ADDED, 2'd0, 32'd0, 16'd0, r_self_id, r_self_port, 32'd0);
			if (r_self_id == r_intro_id && r_self_port == r_intro_port)
				joined = 1'b1;
			else
				add_word(hbm_pkg::EV_SEND, hbm_pkg::MSG_JOIN_REQ, r_intro_id, r_intro_port,
					r_self_id, r_self_port, my_beat);
		end else if (req == hbm_pkg::REQ_MSG && n_entries != 0) begin
			if (kind == hbm_pkg::MSG_JOIN_REQ)
				add_word(hbm_pkg::EV_SEND, hbm_pkg::MSG_JOIN_REP, sid, sport,
					r_self_id, r_self_port, my_beat);
			else if (kind == hbm_pkg::MSG_JOIN_REP)
				joined = 1'b1;
			found = 0;
			for (i = 0; i < n_entries && !found; i++) begin
				if (t_id[i] == sid && t_port[i] == sport) begin
					found = 1;
					if (mbeat > t_beat[i]) begin
						t_beat[i] = mbeat; t_heard[i] = now;
						for (k = 1; k < n_entries; k++)
							if (!entry_is_self(k))
								add_word(hbm_pkg::EV_SEND, hbm_pkg::MSG_BEAT, t_id[k], t_port[k],
									sid, sport, mbeat);
					end
				end
			end
			if (!found) begin
				if (n_entries < DEPTH) begin
					t_id[n_entries] = sid; t_port[n_entries] = sport;
					t_beat[n_entries] = mbeat; t_heard[n_entries] = now;
					n_entries++;
					add_word(hbm_pkg::EV_ADDED, 2'd0, 32'd0, 16'd0, sid, sport, 32'd0);
				end else begin
					add_word(hbm_pkg::EV_DROP, 2'd0, 32'd0, 16'd0, sid, sport, 32'd0);
				end
			end
		end else if (req == hbm_pkg::REQ_TICK && n_entries != 0 && joined) begin
			if (countdown == 0) begin
				my_beat++;
				for (i = 0; i < n_entries; i++)
					if (entry_is_self(i))
						t_beat[i] = my_beat;
					else
						add_word(hbm_pkg::EV_SEND, hbm_pkg::MSG_BEAT, t_id[i], t_port[i],
							r_self_id, r_self_port, my_beat);
				countdown = r_period;
			end else begin
				countdown--;
			end
			i = 1;
			while (i < n_entries) begin
				if (now - t_heard[i] > {16'd0, r_timeout}) begin
					add_word(hbm_pkg::EV_REMOVE, 2'd0, 32'd0, 16'd0, t_id[i], t_port[i], 32'd0);
					for (k = i; k + 1 < n_entries; k++) begin
						t_id[k] = t_id[k+1]; t_port[k] = t_port[k+1];
						t_beat[k] = t_beat[k+1]; t_heard[k] = t_heard[k+1];
					end
					n_entries--;
				end else begin
					i++;
				end
			end
		end
		if (step_words.size() > 0)
			step_words[step_words.size()-1].lst = 1;
		foreach (step_words[j])
			expected_words = {expected_words, step_words[j]};
	endfunction

	// Compares each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		word_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser[1:0], m_tuser[3:2], m_tdata[31:0], m_tdata[47:32],
				m_tdata[79:48], m_tdata[95:80], m_tdata[127:96], m_tlast};
			if (expected_words.size() == 0) begin
				$display("%0t: expected none actual %h", $time, got);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					$display("%0t: expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	// Receiver stalls; a hold-off blocks output for a long stretch.
	always @(posedge clk) begin
		if (stall_req > 0 && !stall_taken) begin
			stall_taken <= 1'b1;
			hold_off <= stall_req;
			m_tready <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else if ($urandom_range(0, 99) < 8) begin
			m_tready <= 0;
		end else if ($urandom_range(0, 99) < 2) begin
			hold_off <= $urandom_range(20, 60);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// The previous word stays offered until a gap begins; the block is busy then.
	task automatic send_word(logic [1:0] req, logic [1:0] kind, logic [31:0] now,
			logic [31:0] sid, logic [15:0] sport, logic [31:0] mbeat);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= {kind, req};
		s_tdata <= {mbeat, sport, sid, now};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_membership(req, kind, now, sid, sport, mbeat);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			hbm_pkg::CFG_SELF_ID: r_self_id = val;
			hbm_pkg::CFG_SELF_PORT: r_self_port = val[15:0];
			hbm_pkg::CFG_INTRO_ID: r_intro_id = val;
			hbm_pkg::CFG_INTRO_PORT: r_intro_port = val[15:0];
			hbm_pkg::CFG_PERIOD: r_period = val[7:0];
			hbm_pkg::CFG_TIMEOUT: r_timeout = val[15:0];
			default: ;
		endcase
	endtask

	// Lets the block drain before registers change.
	task automatic wait_idle();
		s_tvalid <= 0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4 * DEPTH + 20) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] sid, logic [15:0] sp, logic [31:0] iid,
			logic [15:0] ip, logic [7:0] per, logic [15:0] tmo);
		wait_idle();
		write_reg(hbm_pkg::CFG_SELF_ID, sid);
		write_reg(hbm_pkg::CFG_SELF_PORT, {16'd0, sp});
		write_reg(hbm_pkg::CFG_INTRO_ID, iid);
		write_reg(hbm_pkg::CFG_INTRO_PORT, {16'd0, ip});
		write_reg(hbm_pkg::CFG_PERIOD, {24'd0, per});
		write_reg(hbm_pkg::CFG_TIMEOUT, {16'd0, tmo});
		cfg_we <= 0;
	endtask

	// Directed: items before start, extremes, joins, full table, odd codes.
	task automatic test_directed();
		int i;
		send_word(hbm_pkg::REQ_TICK, NO_KIND, 32'd0, 32'd0, 16'd0, 32'd0);
		send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_BEAT, 32'd0, 32'd5, 16'd5, 32'd5);
		send_word(hbm_pkg::REQ_START, NO_KIND, 32'd10, 32'd0, 16'd0, 32'd0);
		send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_JOIN_REP, 32'd11, 32'd1, 16'd0, 32'd0);
		send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_JOIN_REQ, 32'd12, 32'hFFFF_FFFF, 16'hFFFF,
			32'hFFFF_FFFF);
		send_word(hbm_pkg::REQ_MSG, MSG_UNKNOWN, 32'd13, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
		for (i = 0; i < 15; i++)
			send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_BEAT, 32'd14, 100 + i, 16'(i), 32'd1);
		send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_BEAT, 32'd15, 32'd1, 16'd0, 32'hFFFF_FFFF);
		send_word(REQ_UNKNOWN, NO_KIND, 32'd15, 32'd0, 16'd0, 32'd0);
		send_word(hbm_pkg::REQ_TICK, NO_KIND, 32'd15, 32'd0, 16'd0, 32'd0);
		send_word(hbm_pkg::REQ_TICK, NO_KIND, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'd0);
	endtask

	// Random: mostly join and beat traffic among a small set of peers, ticks in time.
	task automatic test_random(int count);
		int i, r;
		logic [1:0] kind;
		for (i = 0; i < count; i++) begin
			clock_now += $urandom_range(0, 6);
			r = $urandom_range(0, 99);
			kind = 2'($urandom_range(0, 3));
			if (r < 3)
				send_word(hbm_pkg::REQ_START, NO_KIND, clock_now, 32'd0, 16'd0, 32'd0);
			else if (r < 40)
				send_word(hbm_pkg::REQ_TICK, kind, clock_now, $urandom, 16'($urandom),
					$urandom);
			else if (r < 90)
				send_word(hbm_pkg::REQ_MSG, kind, clock_now, $urandom_range(0, 19),
					16'($urandom_range(0, 1)), $urandom_range(0, 30));
			else if (r < 97)
				send_word(hbm_pkg::REQ_MSG, kind, $urandom, $urandom, 16'($urandom), $urandom);
			else
				send_word(REQ_UNKNOWN, kind, $urandom, $urandom, 16'($urandom), $urandom);
		end
	endtask

	// Pressure: output blocked long while inputs keep coming.
	task automatic test_backpressure();
		int i;
		stall_req = 400;
		send_word(hbm_pkg::REQ_START, NO_KIND, clock_now, 32'd0, 16'd0, 32'd0);
		for (i = 0; i < 12; i++)
			send_word(hbm_pkg::REQ_MSG, hbm_pkg::MSG_BEAT, clock_now, 200 + i, 16'd7, 32'd1);
		for (i = 0; i < 6; i++)
			send_word(hbm_pkg::REQ_TICK, NO_KIND, clock_now, 32'd0, 16'd0, 32'd0);
	endtask

	initial begin
		r_self_id = 0; r_self_port = 0; r_intro_id = 1; r_intro_port = 0;
		r_period = 5; r_timeout = 20;
		n_entries = 0; my_beat = 0; countdown = 0; joined = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		configure(32'd0, 16'd0, 32'd0, 16'd0, 8'd0, 16'd0);
		test_random(40);
		configure(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_word(hbm_pkg::REQ_START, NO_KIND, clock_now, 32'd0, 16'd0, 32'd0);
		test_random(40);
		configure(32'd3, 16'd1, 32'd0, 16'd0, 8'd2, 16'd12);
		test_random(55);
		configure(32'd0, 16'd1, 32'd0, 16'd1, 8'd1, 16'd30);
		test_backpressure();
		test_random(50);
		wait_idle();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
